// ===== src/als_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_pkg: shared types and constants for the aliquot sum block
// Default widths and the divider status group.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int unsigned VALUE_BITS_DEF = 20;
  localparam int unsigned SUM_BITS       = 22;
  localparam int unsigned SUM_BYTES_W    = ((SUM_BITS + 7) / 8) * 8;

  // divider status, returned to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== src/als_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_div: iterative restoring divider
// One quotient bit per cycle; quotient and remainder valid on done.
// ----------------------------------------------------------------------------
module als_div #(
  parameter int unsigned W  = 20,  // dividend width
  parameter int unsigned DW = 11   // divisor width
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [DW-1:0]     divisor,
  output logic [W-1:0]      quotient,
  output logic [DW-1:0]     remainder,
  output als_pkg::div_sts_t sts
);
  import als_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial = {rem_r, q_r[W-1]};
  assign ge    = (trial >= {1'b0, dv_r});
  assign diff  = trial - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[W-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;

endmodule

// ===== src/aliquot_sum_perfect_test_top.sv =====
`timescale 1ns / 1ps
// The shared one-bit-per-cycle divider is run once per trial divisor d, while d*d <= n.
// One item at a time: the search for one candidate ends before the next beat is taken.
// in_tready is high only while the sequencer is idle; a finished result waits in the
//   output register and the next beat may be accepted while it is held.
// Reset: synchronous, active low; clears the sequencer, divider control and out_tvalid.
// ----------------------------------------------------------------------------
// aliquot_sum_perfect_test_top: aliquot sum and perfect-number test
// Sums proper divisors of the input by trial division with a shared divider.
// ----------------------------------------------------------------------------
module aliquot_sum_perfect_test_top #(
  parameter int unsigned VALUE_BITS = als_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beat
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] in_tdata,   // [VALUE_BITS-1:0] candidate_value
  // result beat
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [als_pkg::SUM_BYTES_W-1:0]     out_tdata,  // [21:0] divisor_sum, rest zero
  output logic                                out_tuser   // [0] is_perfect
);
  import als_pkg::*;

  // trial divisor width: holds floor(sqrt(2^VALUE_BITS - 1)) + 1
  localparam int unsigned DW  = (VALUE_BITS + 1) / 2 + 1;
  // running square of the trial divisor
  localparam int unsigned SQW = 2 * DW;
  // exact sum fits in VALUE_BITS + 3 bits
  localparam int unsigned AW  = VALUE_BITS + 3;
  // compare width for saturation
  localparam int unsigned CW  = (AW > SUM_BITS) ? AW : SUM_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,   // test d*d <= n, launch divide
    ST_DIV,     // wait for divider
    ST_ADD_D,   // sum += d
    ST_ADD_CO,  // sum += n/d unless it equals d
    ST_DONE     // park result in output register
  } state_t;

  state_t               state_r;
  logic [VALUE_BITS-1:0] n_r;
  logic [DW-1:0]        d_r;
  logic [SQW-1:0]       sq_r;
  logic [AW-1:0]        acc_r;
  logic [VALUE_BITS-1:0] co_r;
  logic                 out_tvalid_r;
  logic [SUM_BITS-1:0]  sum_out_r;
  logic                 perfect_r;

  logic [VALUE_BITS-1:0] div_q;
  logic [DW-1:0]        div_rem;
  div_sts_t             div_sts;
  logic                 div_start;
  logic                 sq_le_n;
  logic [SQW-1:0]       sq_step;
  logic [CW-1:0]        acc_ext;
  logic                 sat;

  assign sq_le_n   = (sq_r <= SQW'(n_r));
  assign div_start = (state_r == ST_CHECK) && sq_le_n;
  // (d+1)^2 = d^2 + 2d + 1
  assign sq_step   = sq_r + SQW'({d_r, 1'b1});
  assign acc_ext   = CW'(acc_r);
  assign sat       = (acc_ext > CW'({SUM_BITS{1'b1}}));

  als_div #(
    .W  (VALUE_BITS),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // in ST_DONE the output register is handled by the sequencer below
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            n_r     <= in_tdata[VALUE_BITS-1:0];
            d_r     <= DW'(2);
            sq_r    <= SQW'(4);
            acc_r   <= AW'(1);
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= sq_le_n ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_sts.done) begin
            co_r <= div_q;
            if (div_rem == '0) begin
              state_r <= ST_ADD_D;
            end else begin
              d_r     <= d_r + 1'b1;
              sq_r    <= sq_step;
              state_r <= ST_CHECK;
            end
          end
        end
        ST_ADD_D: begin
          acc_r   <= acc_r + AW'(d_r);
          state_r <= ST_ADD_CO;
        end
        ST_ADD_CO: begin
          if (co_r != VALUE_BITS'(d_r)) begin
            acc_r <= acc_r + AW'(co_r);
          end
          d_r     <= d_r + 1'b1;
          sq_r    <= sq_step;
          state_r <= ST_CHECK;
        end
        ST_DONE: begin
          // hold until the output register is free or draining this cycle
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            sum_out_r    <= sat ? {SUM_BITS{1'b1}} : acc_ext[SUM_BITS-1:0];
            perfect_r    <= (n_r >= VALUE_BITS'(2)) && (AW'(n_r) == acc_r);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = SUM_BYTES_W'(sum_out_r);
  assign out_tuser  = perfect_r;

`ifndef SYNTHESIS
  // an accepted beat always starts a search
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CHECK))
    else $error("accepted beat did not start the search");

  // divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIV))
    else $error("divider finished outside ST_DIV");

  // divider idle whenever a new beat can be taken
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_sts.busy)
    else $error("divider busy while idle");

  // incremental square tracks the trial divisor
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sq_r == SQW'(d_r) * SQW'(d_r)))
    else $error("square register out of step with trial divisor");

  // a launched divide is seen busy on the next cycle
  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_sts.busy)
    else $error("divide launch not taken");
`endif

endmodule

// ===== tb/tb_aliquot_sum_perfect_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aliquot_sum_perfect_test_top: self-checking bench for the aliquot sum block
// Drives candidate numbers into the input stream and predicts each divisor
// sum and perfect flag. Every result beat is compared against the oldest
// pending prediction. Both stream sides idle at random, and one phase forces a
// long output stall. Directed phases cover zero, one, primes, perfect numbers,
// perfect squares and the ends of the range. A random phase follows.
// ----------------------------------------------------------------------------
module tb_aliquot_sum_perfect_test_top;

  localparam int unsigned VALUE_BITS = als_pkg::VALUE_BITS_DEF;
  localparam int unsigned SUM_BITS   = als_pkg::SUM_BITS;
  localparam int unsigned IN_W       = ((VALUE_BITS + 7) / 8) * 8;
  localparam logic [63:0] SUM_MAX    = (64'd1 << SUM_BITS) - 64'd1;
  localparam int unsigned VALUE_MAX  = (1 << VALUE_BITS) - 1;

  // worst single item: about 1023 trial divisors, each one full divide
  localparam int unsigned MAX_ITEM_CYCLES = 23000;
  // output stall long enough to cover several small items
  localparam int unsigned HOLD_CYCLES     = 3000;
  localparam int unsigned RANDOM_ITEMS    = 60;

  // one predicted result beat
  typedef struct {
    logic [VALUE_BITS-1:0] candidate;
    logic [SUM_BITS-1:0]   divisor_sum;
    logic                  is_perfect;
  } aliquot_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [als_pkg::SUM_BYTES_W-1:0] out_tdata;
  logic                     out_tuser;

  aliquot_result_t pending_results[$];
  int unsigned     error_count = 0;

  // idling controls, flipped by the test tasks
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned sink_hold_req = 0;   // cycles of forced out_tready low

  aliquot_sum_perfect_test_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),     // [19:0] candidate_value, rest zero
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),    // [21:0] divisor_sum, rest zero
    .out_tuser (out_tuser)     // [0] is_perfect
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #150_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: sum starts at 1; each divisor d <= isqrt(n) adds d and n/d,
  // a square root only once. Perfect needs n >= 2 and n == exact sum.
  // --------------------------------------------------------------------------
  function automatic aliquot_result_t predict_aliquot(input logic [VALUE_BITS-1:0] value);
    logic [63:0]     n;
    logic [63:0]     d;
    logic [63:0]     cofactor;
    logic [63:0]     acc;
    aliquot_result_t res;
    n   = 64'(value);
    acc = 64'd1;
    for (d = 64'd2; d * d <= n; d++) begin
      if (n % d == 64'd0) begin
        cofactor = n / d;
        acc += d;
        if (cofactor != d) acc += cofactor;
      end
    end
    res.candidate   = value;
    // saturation only matters for wider builds, kept for safety
    res.divisor_sum = (acc > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : acc[SUM_BITS-1:0];
    res.is_perfect  = (n >= 64'd2) && (n == acc);
    return res;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one beat, wait for the handshake, log the prediction.
  // tvalid stays high only when the next beat follows in the same step.
  // --------------------------------------------------------------------------
  task automatic send_candidate(input int unsigned value, input bit more);
    int unsigned gap;
    in_tdata  <= IN_W'(value[VALUE_BITS-1:0]);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_aliquot(value[VALUE_BITS-1:0]));
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0 || !more) begin
      in_tvalid <= 1'b0;
      repeat ((gap > 0) ? gap : 1) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random out_tready, plus forced holds requested by the tests.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (sink_hold_req > 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall_left == 0 && sink_idle_on) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each accepted result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    aliquot_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: divisor_sum %0d, is_perfect %0d",
               out_tdata[SUM_BITS-1:0], out_tuser);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[SUM_BITS-1:0] !== exp_res.divisor_sum) begin
          $error("divisor_sum for %0d: expected %0d, actual %0d", exp_res.candidate,
                 exp_res.divisor_sum, out_tdata[SUM_BITS-1:0]);
          error_count++;
        end
        if (out_tuser !== exp_res.is_perfect) begin
          $error("is_perfect for %0d: expected %0d, actual %0d", exp_res.candidate,
                 exp_res.is_perfect, out_tuser);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test phases
  // --------------------------------------------------------------------------

  // zero and one (no trial divisor), small primes, range ends, powers of two
  task automatic test_edge_values();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_candidate(0, 1'b1);
    send_candidate(1, 1'b1);
    send_candidate(2, 1'b1);
    send_candidate(3, 1'b1);
    send_candidate(97, 1'b1);
    send_candidate(65536, 1'b1);
    send_candidate(524288, 1'b1);
    send_candidate(1048573, 1'b1);
    send_candidate(VALUE_MAX, 1'b0);   // all ones
  endtask

  // the four perfect numbers in range, the neighbors of 8128, and abundant values
  task automatic test_perfect_numbers();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_candidate(6, 1'b1);
    send_candidate(28, 1'b1);
    send_candidate(496, 1'b1);
    send_candidate(8127, 1'b1);
    send_candidate(8128, 1'b1);
    send_candidate(8129, 1'b1);
    send_candidate(12, 1'b1);
    send_candidate(720720, 1'b0);
  endtask

  // square root divisor must be counted once
  task automatic test_perfect_squares();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    send_candidate(4, 1'b1);
    send_candidate(9, 1'b1);
    send_candidate(16, 1'b1);
    send_candidate(25, 1'b1);
    send_candidate(36, 1'b1);
    send_candidate(49, 1'b1);
    send_candidate(1046529, 1'b0);     // 1023 squared, largest square in range
  endtask

  // long output stall while the sender keeps offering small items,
  // so the held result plus the next one back up into in_tready
  task automatic test_output_backpressure();
    src_idle_on   = 1'b0;
    sink_idle_on  = 1'b0;
    sink_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) send_candidate($urandom_range(2, 300), i < 5);
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int i = 0; i < 4; i++) send_candidate($urandom_range(1, 4095), i < 3);
    wait_results_drained();
    for (int i = 0; i < 4; i++) send_candidate($urandom_range(1, 4095), i < 3);
  endtask

  // random candidates, mostly small to keep run time down, a few full range
  task automatic test_random_mix();
    int unsigned r;
    int unsigned value;
    int unsigned root;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // first quarter runs without idling on either side
      src_idle_on  = (i >= RANDOM_ITEMS / 4);
      sink_idle_on = (i >= RANDOM_ITEMS / 4);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        value = $urandom_range(1, 1023);
      end else if (r < 80) begin
        value = $urandom_range(1024, 65535);
      end else if (r < 88) begin
        root  = $urandom_range(2, 1023);
        value = root * root;
      end else begin
        value = $urandom_range(1, VALUE_MAX);
      end
      send_candidate(value, i < RANDOM_ITEMS - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_perfect_numbers();
    test_perfect_squares();
    test_output_backpressure();
    test_drain_pause();
    test_random_mix();

    // everything back, then watch for stray beats one item time longer
    wait_results_drained();
    repeat (MAX_ITEM_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== aliquot_sum_perfect_test_top.f =====
src/als_pkg.sv
src/als_div.sv
src/aliquot_sum_perfect_test_top.sv
tb/tb_aliquot_sum_perfect_test_top.sv
